// File: rtl/lcdt_pkg.sv
`default_nettype none

package lcdt_pkg;

   // Fixed timing of one line and one frame, in dots and lines.
   localparam logic [8:0]  OAM_DOTS      = 9'd80;
   localparam logic [8:0]  DRAW_DOTS     = 9'd172;
   localparam logic [8:0]  LINE_DOTS     = 9'd456;
   localparam logic [16:0] FRAME_DOTS    = 17'd70224;
   localparam logic [7:0]  VISIBLE_LINES = 8'd144;
   localparam logic [7:0]  TOTAL_LINES   = 8'd154;

   // Reset values of the horizontal blank length registers.
   localparam logic [8:0] HBLANK_ALIGNED_RESET     = 9'd204;
   localparam logic [8:0] HBLANK_SMALL_SHIFT_RESET = 9'd200;
   localparam logic [8:0] HBLANK_LARGE_SHIFT_RESET = 9'd196;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HBLANK_ALIGNED     = 2'd0;
   localparam logic [1:0] CSR_HBLANK_SMALL_SHIFT = 2'd1;
   localparam logic [1:0] CSR_HBLANK_LARGE_SHIFT = 2'd2;

   // One dot tick with the register bits that it carries.
   typedef struct packed {
      logic       display_on;
      logic [2:0] fine_scroll;
      logic [7:0] compare_line;
      logic       sel_hblank_irq;
      logic       sel_vblank_irq;
      logic       sel_oam_irq;
      logic       sel_compare_irq;
   } req_type;

   // Status after one dot tick.
   typedef struct packed {
      logic [1:0] video_mode;
      logic [7:0] current_line;
      logic       line_match;
      logic       vblank_irq;
      logic       status_irq;
      logic       frame_done;
      logic       line_drawn;
   } rsp_type;

   // Horizontal blank lengths, one for each fine scroll class.
   typedef struct packed {
      logic [8:0] aligned;
      logic [8:0] small_shift;
      logic [8:0] large_shift;
   } hblank_cfg_type;

endpackage

`default_nettype wire

// File: rtl/lcdt_csr.sv
`default_nettype none

module lcdt_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_en,
   input  wire logic [1:0]              wr_index,
   input  wire logic [8:0]              wr_data,
   output      lcdt_pkg::hblank_cfg_type cfg
);

   lcdt_pkg::hblank_cfg_type cfg_ff;
   lcdt_pkg::hblank_cfg_type cfg_in;

   // Register decode; an index past the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            lcdt_pkg::CSR_HBLANK_ALIGNED:     cfg_in.aligned     = wr_data;
            lcdt_pkg::CSR_HBLANK_SMALL_SHIFT: cfg_in.small_shift = wr_data;
            lcdt_pkg::CSR_HBLANK_LARGE_SHIFT: cfg_in.large_shift = wr_data;
            default:                          cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aligned     <= lcdt_pkg::HBLANK_ALIGNED_RESET;
         cfg_ff.small_shift <= lcdt_pkg::HBLANK_SMALL_SHIFT_RESET;
         cfg_ff.large_shift <= lcdt_pkg::HBLANK_LARGE_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/lcdt_timing.sv
`default_nettype none

module lcdt_timing (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire lcdt_pkg::req_type        item,
   input  wire lcdt_pkg::hblank_cfg_type cfg,
   output      lcdt_pkg::rsp_type        result
);

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [8:0]        dot_ff, dot_in;
   logic [7:0]        line_ff, line_in;
   logic [16:0]       off_ff, off_in;
   logic              status_high_ff, status_high_in;
   logic              match_ff, match_in;
   logic              prev_on_ff;
   lcdt_pkg::rsp_type result_ff, result_in;

   logic [8:0]  dot_inc;
   logic [7:0]  line_inc;
   logic [16:0] off_inc;
   logic [8:0]  hblank_len;
   logic        match_inc;
   logic        match_zero;
   logic        cond_oam_inc;
   logic        cond_vblank_inc;
   logic        cond_oam_zero;
   logic        cond_hblank;

   assign dot_inc  = dot_ff + 9'd1;
   assign line_inc = line_ff + 8'd1;
   // A falling enable restarts the disabled dot count before this dot.
   assign off_inc  = (prev_on_ff ? 17'd0 : off_ff) + 17'd1;

   // Horizontal blank length follows the fine scroll class.
   always_comb begin
      case (item.fine_scroll) inside
         3'd0:          hblank_len = cfg.aligned;
         [3'd1 : 3'd3]: hblank_len = cfg.small_shift;
         default:       hblank_len = cfg.large_shift;
      endcase
   end

   // Line compare against the advanced line and against line zero after a wrap.
   assign match_inc       = (item.compare_line == line_inc);
   assign match_zero      = (item.compare_line == 8'd0);
   assign cond_oam_inc    = item.sel_oam_irq || (item.sel_compare_irq && match_inc);
   assign cond_vblank_inc = item.sel_vblank_irq || (item.sel_compare_irq && match_inc);
   assign cond_oam_zero   = item.sel_oam_irq || (item.sel_compare_irq && match_zero);
   assign cond_hblank     = item.sel_hblank_irq || (item.sel_compare_irq && match_ff);

   // Next state and result of one dot tick.
   always_comb begin
      mode_in        = mode_ff;
      dot_in         = dot_ff;
      line_in        = line_ff;
      off_in         = off_ff;
      status_high_in = status_high_ff;
      match_in       = match_ff;
      result_in      = '0;

      if (!item.display_on) begin
         if (prev_on_ff) begin
            mode_in = MODE_HBLANK;
            line_in = 8'd0;
         end
         if (off_inc >= lcdt_pkg::FRAME_DOTS) begin
            off_in               = 17'd0;
            result_in.frame_done = 1'b1;
         end else begin
            off_in = off_inc;
         end
      end else begin
         dot_in = dot_inc;
         unique case (mode_ff)
            MODE_HBLANK: begin
               if (dot_inc >= hblank_len) begin
                  dot_in   = 9'd0;
                  line_in  = line_inc;
                  match_in = match_inc;
                  if (line_inc == lcdt_pkg::VISIBLE_LINES) begin
                     mode_in              = MODE_VBLANK;
                     result_in.vblank_irq = 1'b1;
                     result_in.frame_done = 1'b1;
                     result_in.status_irq = item.sel_oam_irq && !status_high_ff;
                     status_high_in       = item.sel_oam_irq;
                  end else begin
                     mode_in              = MODE_OAM;
                     result_in.status_irq = cond_oam_inc && !status_high_ff;
                     status_high_in       = cond_oam_inc;
                  end
               end
            end
            MODE_VBLANK: begin
               if (dot_inc >= lcdt_pkg::LINE_DOTS) begin
                  dot_in   = 9'd0;
                  line_in  = line_inc;
                  match_in = match_inc;
                  result_in.status_irq = cond_vblank_inc && !status_high_ff;
                  status_high_in       = cond_vblank_inc;
                  if (line_inc >= lcdt_pkg::TOTAL_LINES) begin
                     // Frame wrap: a second status check on line zero.
                     mode_in  = MODE_OAM;
                     line_in  = 8'd0;
                     match_in = match_zero;
                     result_in.status_irq = (cond_vblank_inc && !status_high_ff) ||
                                            (cond_oam_zero && !cond_vblank_inc);
                     status_high_in       = cond_oam_zero;
                  end
               end
            end
            MODE_OAM: begin
               if (dot_inc >= lcdt_pkg::OAM_DOTS) begin
                  dot_in  = 9'd0;
                  mode_in = MODE_DRAW;
               end
            end
            MODE_DRAW: begin
               if (dot_inc >= lcdt_pkg::DRAW_DOTS) begin
                  dot_in               = 9'd0;
                  mode_in              = MODE_HBLANK;
                  result_in.status_irq = cond_hblank && !status_high_ff;
                  status_high_in       = cond_hblank;
                  result_in.line_drawn = 1'b1;
               end
            end
         endcase
      end

      result_in.video_mode   = mode_in;
      result_in.current_line = line_in;
      result_in.line_match   = match_in;
   end

   // State and result register, advanced once per dot tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HBLANK;
         dot_ff         <= 9'd0;
         line_ff        <= 8'd0;
         off_ff         <= 17'd0;
         status_high_ff <= 1'b0;
         match_ff       <= 1'b0;
         prev_on_ff     <= 1'b0;
         result_ff      <= '0;
      end else if (step_en) begin
         mode_ff        <= mode_in;
         dot_ff         <= dot_in;
         line_ff        <= line_in;
         off_ff         <= off_in;
         status_high_ff <= status_high_in;
         match_ff       <= match_in;
         prev_on_ff     <= item.display_on;
         result_ff      <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// File: rtl/lcd_mode_timing_controller_core.sv
// Scanline mode and timing controller of a dot-matrix LCD unit.
// The req channel carries one dot tick per transfer: the enable bit, fine
// scroll, compare line and the four status interrupt selects. The rsp channel
// returns one status item per tick: video mode, line counter, compare flag and
// the vblank, status, frame done and line drawn pulses.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low. The csr channel (valid, ready, index, data)
// writes the three horizontal blank lengths and is always ready; write it
// only while no tick is in flight.
// A req transfer goes through the input register, the mode and counter
// update and the result register before rsp_valid rises. Throughput is
// one tick per cycle while rsp is not stalled. A stalled rsp holds its item;
// the input register still takes one more tick, after which req_stall rises.
// Synchronous reset empties both registers, puts the mode in horizontal blank,
// clears all counters and flags and restores the blank length defaults.
`default_nettype none

module lcd_mode_timing_controller_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire lcdt_pkg::req_type req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      lcdt_pkg::rsp_type rsp_payload,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [8:0]        csr_data
);

   logic                     in_valid_ff, in_valid_in;
   lcdt_pkg::req_type        in_data_ff;
   logic                     out_valid_ff, out_valid_in;
   logic                     advance;
   logic                     in_free;
   lcdt_pkg::hblank_cfg_type cfg;

   // A tick moves into the result register when that register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_free   = !in_valid_ff || advance;
   assign req_stall = !in_free;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_free ? req_valid : in_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         in_data_ff <= req_payload;
      end
   end

   lcdt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   lcdt_timing u_timing (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (rsp_payload)
   );

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire
